>>> src/ghvw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghvw_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers, table indexing and the sequencer states used by the
// gravity harmonic V'/W' recursion block and its arithmetic units.
// ----------------------------------------------------------------------------
package ghvw_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int FRAC_BITS  = 60;
    localparam int TABLE_SIZE = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int DEG_W      = 6;
    localparam int POS_W      = 48;
    localparam int RAD_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_W        = 64;
    localparam int NUM_W      = 128;
    localparam int PROD_W     = 128;
    localparam int R2_W       = 96;
    localparam int SCALE_SH   = FRAC_BITS + 15;

    localparam logic [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W:0] SUM_HI = $signed({2'b00, {(Q_W-1){1'b1}}});
    localparam logic signed [Q_W:0] SUM_LO = -SUM_HI;

    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER        = 2'd2;

    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);
    localparam logic [DEG_W-1:0] DEG_MIN = 6'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQW, S_ZCHK, S_SQRT, S_SQRTW, S_DIVA, S_DIVAW,
        S_DIVU, S_DIVUW, S_MULS, S_MULSW, S_MULE, S_MULEW, S_ENT, S_HDIV,
        S_HDIVW, S_HMUL, S_HMULW, S_RD1, S_RD2, S_RD3, S_PMUL, S_PMULW,
        S_COMB, S_WR, S_RDQ, S_RDQ2, S_OUT
    } state_t;

    typedef enum logic {DS_DIV, DS_SQRT} ds_mode_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic over;
    } ds_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Magnitude of a signed word as an unsigned word.
    function automatic logic [Q_W-1:0] mag64(logic [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Round a raw magnitude product to nearest, saturate, apply the sign.
    // Returns {saturated, value}.
    function automatic logic [Q_W:0] mulq_fin(logic [PROD_W-1:0] prod, logic neg);
        logic [PROD_W-1:0]           p;
        logic [PROD_W-FRAC_BITS-1:0] q;
        logic [Q_W-1:0]              m;
        logic                        ov;
        p  = prod + (PROD_W'(1) << (FRAC_BITS - 1));
        q  = (PROD_W-FRAC_BITS)'(p >> FRAC_BITS);
        ov = q > (PROD_W-FRAC_BITS)'(QMAX);
        m  = ov ? QMAX : q[Q_W-1:0];
        return {ov, neg ? (~m + 1'b1) : m};
    endfunction

    // Saturating sum or difference, clamped to plus or minus QMAX.
    function automatic logic [Q_W:0] sat_sum(logic [Q_W-1:0] a, logic [Q_W-1:0] b,
                                             logic sub);
        logic signed [Q_W:0] s;
        s = sub ? ($signed({a[Q_W-1], a}) - $signed({b[Q_W-1], b}))
                : ($signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b}));
        if (s > SUM_HI) begin
            return {1'b1, QMAX};
        end
        else if (s < SUM_LO) begin
            return {1'b1, ~QMAX + 1'b1};
        end
        return {1'b0, s[Q_W-1:0]};
    endfunction

    // Saturate a quotient magnitude and apply the sign.
    function automatic logic [Q_W:0] sat_quo(logic [Q_W-1:0] quo, logic over, logic neg);
        logic [Q_W-1:0] m;
        m = over ? QMAX : quo;
        return {over, neg ? (~m + 1'b1) : m};
    endfunction

    // Triangular table index n(n+1)/2 + m.
    function automatic logic [IDX_W-1:0] tab_ix(logic [DEG_W-1:0] n, logic [DEG_W-1:0] m);
        logic [12:0] t;
        t = (13'(n) * (13'(n) + 13'd1)) >> 1;
        t = t + 13'(m);
        return IDX_W'(t);
    endfunction

endpackage

>>> src/gravity_harmonic_vw_recursion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_harmonic_vw_recursion: spherical-harmonic V'/W' table engine
// Builds the scaled V'/W' gravity harmonic table for one position and serves
// reads of single entries from it.
// ----------------------------------------------------------------------------
// A compute word (operation 0) takes an Earth-fixed position in millimetres,
// forms r, Re/r, the scaled coordinates and Re^2/r^2, and fills the V'/W'
// table up to the configured degree and order; it answers with V'00 = Re/r,
// W = 0, entry_valid 1 and the overflow flag, or with all zero, entry_valid 0
// and overflow 1 for a zero position. A read word (operation 1) answers with
// V' and W' at (read_degree, read_order), or zeros with entry_valid 0 when
// that entry was not computed. All work runs through one shared 64 x 64
// multiplier and one shared bit-serial divider and square-root unit,
// under a single sequencer, and the block takes one word at a time. A
// compute first does its setup (three squares, one root, four divisions,
// four products), then forms each table entry in turn, dividing out the
// coefficient of the three-term recursion on the fly for the entries that
// use it. Results are signed Q3.60 and saturate to plus or minus
// (2^63 - 1), setting the overflow flag. Degree and order are clamped and
// latched once the setup is done, so later register writes do not change
// what a read returns.
// ----------------------------------------------------------------------------
module gravity_harmonic_vw_recursion
    import ghvw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [RAD_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [DEG_W-1:0]         read_degree,
    input  logic [DEG_W-1:0]         read_order,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [Q_W-1:0]    value_v,
    output logic signed [Q_W-1:0]    value_w,
    output logic                     entry_valid,
    output logic                     overflow
);

    // Configuration registers.
    logic [RAD_W-1:0] earth_radius_reg;
    logic [DEG_W-1:0] degree_reg, order_reg;

    // Sequencer and table status.
    state_t           state_reg, state_next;
    logic [1:0]       k_reg;
    logic [DEG_W-1:0] n_reg, m_reg, d_reg, mlim_reg;
    logic             tv_reg, ovf_reg;

    // Working values of the current compute.
    logic [POS_W-1:0] mg_reg [3];
    logic             ng_reg [3];
    logic [R2_W-1:0]  r2_reg;
    logic [Q_W-1:0]   rq_reg, a_reg, e_reg, u_reg, h_reg, he_reg;
    logic [Q_W-1:0]   s_reg [3];
    logic [Q_W-1:0]   v1_reg, w1_reg, v2_reg, w2_reg;
    logic [Q_W-1:0]   p_reg [4];
    logic [Q_W-1:0]   vres_reg, wres_reg;
    logic             mneg_reg;

    // Pending result and output register.
    logic [Q_W-1:0]   res_v_reg, res_w_reg;
    logic             res_ok_reg;
    logic [IDX_W-1:0] qaddr_reg;
    logic             out_valid_reg, entry_valid_reg, overflow_reg;
    logic [Q_W-1:0]   value_v_reg, value_w_reg;

    // Table memories.
    logic [Q_W-1:0]   v_mem [TABLE_SIZE];
    logic [Q_W-1:0]   w_mem [TABLE_SIZE];
    logic [Q_W-1:0]   rdv_reg, rdw_reg;

    // Unit hookup and control.
    logic              mul_start, mul_neg;
    logic [Q_W-1:0]    mul_a, mul_b;
    mul_stat_t         mul_st;
    logic [PROD_W-1:0] mul_prod;
    ds_ctl_t           ds_ctl;
    ds_stat_t          ds_st;
    logic [NUM_W-1:0]  ds_num;
    logic [Q_W-1:0]    ds_den;
    logic [Q_W-1:0]    ds_quo;
    logic              mem_we;
    logic [IDX_W-1:0]  rd_addr, wr_addr;

    // Derived control terms.
    logic             in_acc, diag, far, last_entry, out_load;
    logic [DEG_W-1:0] deg_clamp, ord_clamp;
    logic [IDX_W-1:0] addr1, addr2;
    logic [11:0]      hnum;
    logic [13:0]      hden;
    logic [Q_W-1:0]   op_x, op_y;
    logic             rd_ok;
    logic [Q_W:0]     mq, sq, sum_v, sum_w;

    ghvw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_st),
        .prod  (mul_prod)
    );

    ghvw_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ds_ctl),
        .num   (ds_num),
        .den   (ds_den),
        .stat  (ds_st),
        .quo   (ds_quo)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // The degree is held between two and the maximum degree; the order never
    // exceeds the degree.
    assign deg_clamp = (degree_reg < DEG_MIN) ? DEG_MIN :
                       (degree_reg > DEG_MAX) ? DEG_MAX : degree_reg;
    assign ord_clamp = (order_reg > deg_clamp) ? deg_clamp : order_reg;

    // Entry geometry: a diagonal entry is seeded from the previous diagonal,
    // and only entries two or more below the diagonal use the recursion
    // coefficient and the entry two degrees back.
    assign diag       = (n_reg == m_reg);
    assign far        = ({1'b0, n_reg} >= ({1'b0, m_reg} + 7'd2));
    assign last_entry = (n_reg == d_reg) && (m_reg == mlim_reg);
    assign addr1      = diag ? tab_ix(m_reg - 1'b1, m_reg - 1'b1)
                             : tab_ix(n_reg - 1'b1, m_reg);
    assign addr2      = tab_ix(n_reg - 6'd2, m_reg);
    assign wr_addr    = tab_ix(n_reg, m_reg);
    assign hnum       = 12'(n_reg + m_reg - 1'b1) * 12'(n_reg - m_reg - 1'b1);
    assign hden       = (14'({n_reg, 1'b0}) - 14'd1) * (14'({n_reg, 1'b0}) - 14'd3);

    assign rd_ok = tv_reg && (read_degree <= d_reg) && (read_order <= read_degree)
                   && (read_order <= mlim_reg);

    // Four products per entry past V'00: diagonal seeds rotate by (x', y'), the rest
    // combine z' times the previous degree with h*e times the one before.
    always_comb
    begin
        case (k_reg)
            2'd0:    begin op_x = diag ? s_reg[0] : s_reg[2]; op_y = v1_reg; end
            2'd1:    begin op_x = diag ? s_reg[1] : he_reg;
                           op_y = diag ? w1_reg : v2_reg; end
            2'd2:    begin op_x = diag ? s_reg[0] : s_reg[2]; op_y = w1_reg; end
            default: begin op_x = diag ? s_reg[1] : he_reg;
                           op_y = diag ? v1_reg : w2_reg; end
        endcase
    end

    assign mq    = mulq_fin(mul_prod, mneg_reg);
    assign sq    = sat_quo(ds_quo, ds_st.over, (state_reg == S_DIVUW) && ng_reg[k_reg]);
    assign sum_v = sat_sum(p_reg[0], p_reg[1], 1'b1);
    assign sum_w = sat_sum(p_reg[2], p_reg[3], !diag);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    state_next = operation ? S_RDQ : S_SQ;
                end
            end
            S_SQ:    state_next = S_SQW;
            S_SQW:
            begin
                if (mul_st.done) begin
                    state_next = (k_reg == 2'd2) ? S_ZCHK : S_SQ;
                end
            end
            S_ZCHK:  state_next = (r2_reg == '0) ? S_OUT : S_SQRT;
            S_SQRT:  state_next = S_SQRTW;
            S_SQRTW: if (ds_st.done) state_next = S_DIVA;
            S_DIVA:  state_next = S_DIVAW;
            S_DIVAW: if (ds_st.done) state_next = S_DIVU;
            S_DIVU:  state_next = S_DIVUW;
            S_DIVUW: if (ds_st.done) state_next = S_MULS;
            S_MULS:  state_next = S_MULSW;
            S_MULSW:
            begin
                if (mul_st.done) begin
                    state_next = (k_reg == 2'd2) ? S_MULE : S_DIVU;
                end
            end
            S_MULE:  state_next = S_MULEW;
            S_MULEW: if (mul_st.done) state_next = S_ENT;
            S_ENT:
            begin
                if (n_reg == '0) begin
                    state_next = S_WR;
                end
                else begin
                    state_next = far ? S_HDIV : S_RD1;
                end
            end
            S_HDIV:  state_next = S_HDIVW;
            S_HDIVW: if (ds_st.done) state_next = S_HMUL;
            S_HMUL:  state_next = S_HMULW;
            S_HMULW: if (mul_st.done) state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_PMUL;
            S_PMUL:  state_next = S_PMULW;
            S_PMULW:
            begin
                if (mul_st.done) begin
                    state_next = (k_reg == 2'd3) ? S_COMB : S_PMUL;
                end
            end
            S_COMB:  state_next = S_WR;
            S_WR:    state_next = last_entry ? S_OUT : S_ENT;
            S_RDQ:   state_next = S_RDQ2;
            S_RDQ2:  state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Unit starts, operand selection and memory ports.
    always_comb
    begin
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        mul_neg     = 1'b0;
        ds_ctl      = '{start: 1'b0, mode: DS_DIV};
        ds_num      = '0;
        ds_den      = rq_reg;
        mem_we      = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_start = 1'b1;
                mul_a     = Q_W'(mg_reg[k_reg]);
                mul_b     = Q_W'(mg_reg[k_reg]);
            end
            S_SQRT:
            begin
                ds_ctl = '{start: 1'b1, mode: DS_SQRT};
                ds_num = NUM_W'({r2_reg, 30'd0});
            end
            S_DIVA:
            begin
                ds_ctl.start = 1'b1;
                ds_num       = NUM_W'({earth_radius_reg, {SCALE_SH{1'b0}}});
            end
            S_DIVU:
            begin
                ds_ctl.start = 1'b1;
                ds_num       = NUM_W'({mg_reg[k_reg], {SCALE_SH{1'b0}}});
            end
            S_MULS:
            begin
                mul_start = 1'b1;
                mul_a     = mag64(u_reg);
                mul_b     = a_reg;
                mul_neg   = u_reg[Q_W-1];
            end
            S_MULE:
            begin
                mul_start = 1'b1;
                mul_a     = a_reg;
                mul_b     = a_reg;
            end
            S_HDIV:
            begin
                ds_ctl.start = 1'b1;
                ds_num       = (NUM_W'(hnum) << FRAC_BITS) + NUM_W'(hden >> 1);
                ds_den       = Q_W'(hden);
            end
            S_HMUL:
            begin
                mul_start = 1'b1;
                mul_a     = h_reg;
                mul_b     = e_reg;
            end
            S_RD1:   rd_addr = addr1;
            S_RD2:   rd_addr = addr2;
            S_PMUL:
            begin
                mul_start = 1'b1;
                mul_a     = mag64(op_x);
                mul_b     = mag64(op_y);
                mul_neg   = op_x[Q_W-1] ^ op_y[Q_W-1];
            end
            S_WR:    mem_we  = 1'b1;
            S_RDQ:   rd_addr = qaddr_reg;
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            k_reg            <= 2'd0;
            n_reg            <= '0;
            m_reg            <= '0;
            d_reg            <= '0;
            mlim_reg         <= '0;
            tv_reg           <= 1'b0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            earth_radius_reg <= 40'd6378137000;
            degree_reg       <= 6'd22;
            order_reg        <= 6'd22;
        end
        else begin
            state_reg <= state_next;

            if (cfg_write) begin
                case (cfg_index)
                    REG_EARTH_RADIUS: earth_radius_reg <= cfg_data;
                    REG_DEGREE:       degree_reg       <= cfg_data[DEG_W-1:0];
                    REG_ORDER:        order_reg        <= cfg_data[DEG_W-1:0];
                    default:          ;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && !operation) begin
                        ovf_reg <= 1'b0;
                        k_reg   <= 2'd0;
                    end
                end
                S_SQW:
                begin
                    if (mul_st.done) begin
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    end
                end
                S_ZCHK:
                begin
                    if (r2_reg == '0) begin
                        ovf_reg <= 1'b1;
                        tv_reg  <= 1'b0;
                    end
                end
                S_DIVAW, S_DIVUW:
                begin
                    if (ds_st.done) begin
                        ovf_reg <= ovf_reg | sq[Q_W];
                    end
                end
                S_MULSW:
                begin
                    if (mul_st.done) begin
                        ovf_reg <= ovf_reg | mq[Q_W];
                        k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    end
                end
                S_MULEW:
                begin
                    if (mul_st.done) begin
                        ovf_reg  <= ovf_reg | mq[Q_W];
                        n_reg    <= '0;
                        m_reg    <= '0;
                        d_reg    <= deg_clamp;
                        mlim_reg <= ord_clamp;
                    end
                end
                S_HMULW:
                begin
                    if (mul_st.done) begin
                        ovf_reg <= ovf_reg | mq[Q_W];
                    end
                end
                S_RD3:   k_reg <= 2'd0;
                S_PMULW:
                begin
                    if (mul_st.done) begin
                        ovf_reg <= ovf_reg | mq[Q_W];
                        k_reg   <= k_reg + 2'd1;
                    end
                end
                S_COMB:  ovf_reg <= ovf_reg | sum_v[Q_W] | sum_w[Q_W];
                S_WR:
                begin
                    if (last_entry) begin
                        tv_reg <= 1'b1;
                    end
                    else if (n_reg < d_reg) begin
                        n_reg <= n_reg + 1'b1;
                    end
                    else begin
                        m_reg <= m_reg + 1'b1;
                        n_reg <= m_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (mul_start) begin
            mneg_reg <= mul_neg;
        end
        if (out_load) begin
            value_v_reg     <= res_v_reg;
            value_w_reg     <= res_w_reg;
            entry_valid_reg <= res_ok_reg;
            overflow_reg    <= ovf_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    if (operation) begin
                        res_ok_reg <= rd_ok;
                        qaddr_reg  <= rd_ok ? tab_ix(read_degree, read_order) : '0;
                    end
                    else begin
                        r2_reg    <= '0;
                        ng_reg[0] <= pos_x[POS_W-1];
                        ng_reg[1] <= pos_y[POS_W-1];
                        ng_reg[2] <= pos_z[POS_W-1];
                        mg_reg[0] <= pos_x[POS_W-1] ? POS_W'(-pos_x) : pos_x;
                        mg_reg[1] <= pos_y[POS_W-1] ? POS_W'(-pos_y) : pos_y;
                        mg_reg[2] <= pos_z[POS_W-1] ? POS_W'(-pos_z) : pos_z;
                    end
                end
            end
            S_SQW:   if (mul_st.done) r2_reg <= r2_reg + R2_W'(mul_prod);
            S_ZCHK:
            begin
                res_v_reg  <= '0;
                res_w_reg  <= '0;
                res_ok_reg <= 1'b0;
            end
            S_SQRTW: if (ds_st.done) rq_reg <= ds_quo;
            S_DIVAW: if (ds_st.done) a_reg  <= sq[Q_W-1:0];
            S_DIVUW: if (ds_st.done) u_reg  <= sq[Q_W-1:0];
            S_MULSW: if (mul_st.done) s_reg[k_reg] <= mq[Q_W-1:0];
            S_MULEW: if (mul_st.done) e_reg <= mq[Q_W-1:0];
            S_ENT:
            begin
                vres_reg <= a_reg;
                wres_reg <= '0;
                he_reg   <= '0;
            end
            S_HDIVW: if (ds_st.done) h_reg  <= ds_quo;
            S_HMULW: if (mul_st.done) he_reg <= mq[Q_W-1:0];
            S_RD2:
            begin
                v1_reg <= rdv_reg;
                w1_reg <= rdw_reg;
            end
            S_RD3:
            begin
                v2_reg <= far ? rdv_reg : '0;
                w2_reg <= far ? rdw_reg : '0;
            end
            S_PMULW: if (mul_st.done) p_reg[k_reg] <= mq[Q_W-1:0];
            S_COMB:
            begin
                vres_reg <= sum_v[Q_W-1:0];
                wres_reg <= sum_w[Q_W-1:0];
            end
            S_WR:
            begin
                if (last_entry) begin
                    res_v_reg  <= a_reg;
                    res_w_reg  <= '0;
                    res_ok_reg <= 1'b1;
                end
            end
            S_RDQ2:
            begin
                res_v_reg <= res_ok_reg ? rdv_reg : '0;
                res_w_reg <= res_ok_reg ? rdw_reg : '0;
            end
            default: ;
        endcase
    end

    // Table storage: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            v_mem[wr_addr] <= vres_reg;
            w_mem[wr_addr] <= wres_reg;
        end
        rdv_reg <= v_mem[rd_addr];
        rdw_reg <= w_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign value_v     = value_v_reg;
    assign value_w     = value_w_reg;
    assign entry_valid = entry_valid_reg;
    assign overflow    = overflow_reg;

    // The sequencer never restarts the multiplier while it is still busy.
    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    // A word that reports no entry carries zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> value_v == '0 && value_w == '0)
        else $error("invalid entry with nonzero value");

    // Table writes stay inside the triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> wr_addr < IDX_W'(TABLE_SIZE))
        else $error("table write out of range");

    // A valid table always has a clamped degree and an order within it.
    assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg |-> d_reg >= DEG_MIN && mlim_reg <= d_reg)
        else $error("latched degree or order out of range");

endmodule

>>> src/ghvw_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghvw_mul: shared 64 x 64 unsigned multiplier
// Forms a 128-bit product from four 32 x 32 partial products, one per cycle,
// with the partial product registered before it is accumulated.
// ----------------------------------------------------------------------------
module ghvw_mul
    import ghvw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [Q_W-1:0]    a,
    input  logic [Q_W-1:0]    b,
    output mul_stat_t         stat,
    output logic [PROD_W-1:0] prod
);

    logic [Q_W-1:0]    a_reg, b_reg;
    logic [Q_W-1:0]    pp_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg, done_reg;
    logic [31:0]       ma, mb;
    logic [PROD_W-1:0] addend;

    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            3'd1:    begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            3'd2:    begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[63:32]; mb = b_reg[63:32]; end
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            3'd1:    addend = PROD_W'(pp_reg);
            3'd4:    addend = PROD_W'(pp_reg) << 64;
            default: addend = PROD_W'(pp_reg) << 32;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= ma * mb;
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

>>> src/ghvw_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghvw_divsqrt: shared bit-serial divider and square root
// Restoring division of a 128-bit numerator by a 64-bit divisor, one quotient
// bit per cycle, or integer square root of a 128-bit word, one bit per cycle.
// ----------------------------------------------------------------------------
module ghvw_divsqrt
    import ghvw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ds_ctl_t          ctl,
    input  logic [NUM_W-1:0] num,
    input  logic [Q_W-1:0]   den,
    output ds_stat_t         stat,
    output logic [Q_W-1:0]   quo
);

    logic [NUM_W-1:0] num_reg;
    logic [Q_W-1:0]   den_reg;
    logic [Q_W+1:0]   rem_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             big_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg, done_reg;
    ds_mode_t         mode_reg;

    logic [Q_W:0]     drem_sh;
    logic [Q_W+3:0]   srem_sh, strial;
    logic             bit_q;
    logic [Q_W+1:0]   rem_next;
    logic [NUM_W-1:0] num_next;

    always_comb
    begin
        drem_sh = {rem_reg[Q_W-1:0], num_reg[NUM_W-1]};
        srem_sh = {rem_reg, num_reg[NUM_W-1:NUM_W-2]};
        strial  = {2'b00, quo_reg, 2'b01};
        if (mode_reg == DS_DIV) begin
            bit_q    = drem_sh >= {1'b0, den_reg};
            rem_next = bit_q ? (Q_W+2)'(drem_sh - {1'b0, den_reg}) : (Q_W+2)'(drem_sh);
            num_next = num_reg << 1;
        end
        else begin
            bit_q    = srem_sh >= strial;
            rem_next = bit_q ? (Q_W+2)'(srem_sh - strial) : (Q_W+2)'(srem_sh);
            num_next = num_reg << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctl.mode == DS_DIV) ? 7'd127 : 7'd63;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start) begin
            num_reg  <= num;
            den_reg  <= den;
            mode_reg <= ctl.mode;
            rem_reg  <= '0;
            quo_reg  <= '0;
            big_reg  <= 1'b0;
        end
        else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[Q_W-2:0], bit_q};
            big_reg <= big_reg | quo_reg[Q_W-1];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.over = big_reg | quo_reg[Q_W-1];
    assign quo       = quo_reg;

endmodule

>>> verif/gravity_harmonic_vw_recursion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_harmonic_vw_recursion_tb: self-checking bench for the V'/W' engine
// Drives compute and read words with random idling on both handshakes and
// checks every answer against a bit-true harmonic table kept in the bench.
// ----------------------------------------------------------------------------
module gravity_harmonic_vw_recursion_tb;
    import ghvw_pkg::*;

    // Operation codes of the input word.
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_READ    = 1'b1;
    // An index that maps to no register; a write to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 40'd6378137000;
    localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [NUM_W-1:0] QMAX_WIDE = NUM_W'(QMAX);
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [Q_W-1:0] v;
        logic signed [Q_W-1:0] w;
        logic                  valid;
        logic                  ovf;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic [DEG_W-1:0] read_degree = '0;
    logic [DEG_W-1:0] read_order = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [Q_W-1:0] value_v;
    logic signed [Q_W-1:0] value_w;
    logic entry_valid;
    logic overflow;

    gravity_harmonic_vw_recursion dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .read_degree(read_degree), .read_order(read_order),
        .out_valid(out_valid), .out_ready(out_ready),
        .value_v(value_v), .value_w(value_w),
        .entry_valid(entry_valid), .overflow(overflow)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bench copy of the block state: registers, coefficient ROM, table.
    logic [RAD_W-1:0] hm_radius;
    logic [DEG_W-1:0] hm_degree_reg;
    logic [DEG_W-1:0] hm_order_reg;
    logic signed [Q_W-1:0] hm_coef [TABLE_SIZE];
    logic signed [Q_W-1:0] hm_v [TABLE_SIZE];
    logic signed [Q_W-1:0] hm_w [TABLE_SIZE];
    int  hm_deg;
    int  hm_ord;
    bit  hm_table_ok;
    bit  hm_ovf;

    answer_t answer_q[$];
    int  send_idle;
    int  recv_idle;
    int  hold_left;
    int  mismatches;
    int  checked;
    int  computes;
    int  reads;

    function automatic int tix(int n, int m);
        return n * (n + 1) / 2 + m;
    endfunction

    // Saturate a magnitude to QMAX and apply the sign.
    function automatic logic signed [Q_W-1:0] clamp_mag(logic [NUM_W-1:0] q, bit neg);
        logic [Q_W-1:0] m;
        if (q > QMAX_WIDE) begin
            hm_ovf = 1'b1;
            m = QMAX;
        end
        else begin
            m = q[Q_W-1:0];
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [Q_W-1:0] absq(logic signed [Q_W-1:0] a);
        return a[Q_W-1] ? Q_W'(-a) : a;
    endfunction

    // Rounded fixed-point product, ties away from zero.
    function automatic logic signed [Q_W-1:0] qmul(logic signed [Q_W-1:0] a,
                                                   logic signed [Q_W-1:0] b);
        logic [NUM_W-1:0] p;
        p = NUM_W'(absq(a)) * NUM_W'(absq(b));
        p = p + (NUM_W'(1) << (FRAC_BITS - 1));
        return clamp_mag(p >> FRAC_BITS, a[Q_W-1] ^ b[Q_W-1]);
    endfunction

    function automatic logic signed [Q_W-1:0] qadd(logic signed [Q_W-1:0] a,
                                                   logic signed [Q_W-1:0] b, bit sub);
        logic signed [Q_W:0] s;
        s = sub ? (Q_W+1)'(a) - (Q_W+1)'(b) : (Q_W+1)'(a) + (Q_W+1)'(b);
        if (s > $signed({1'b0, QMAX})) begin
            hm_ovf = 1'b1;
            return $signed(QMAX);
        end
        if (s < -$signed({1'b0, QMAX})) begin
            hm_ovf = 1'b1;
            return -$signed(QMAX);
        end
        return s[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] root_floor(logic [NUM_W-1:0] x);
        logic [Q_W-1:0] res;
        logic [Q_W-1:0] c;
        res = '0;
        for (int i = Q_W - 1; i >= 0; i--) begin
            c = res | (Q_W'(1) << i);
            if (NUM_W'(c) * NUM_W'(c) <= x) res = c;
        end
        return res;
    endfunction

    task automatic harmonic_reset();
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            hm_coef[i] = '0;
            hm_v[i] = '0;
            hm_w[i] = '0;
        end
        for (int m = 0; m <= MAX_DEGREE; m++) begin
            for (int n = m + 2; n <= MAX_DEGREE; n++) begin
                num = NUM_W'((n + m - 1) * (n - m - 1));
                den = NUM_W'((2 * n - 1) * (2 * n - 3));
                hm_coef[tix(n, m)] = Q_W'(((num << FRAC_BITS) + den / 2) / den);
            end
        end
        hm_deg = 0;
        hm_ord = 0;
        hm_table_ok = 0;
        hm_ovf = 0;
        hm_radius = RADIUS_RESET;
        hm_degree_reg = 6'd22;
        hm_order_reg = 6'd22;
    endtask

    // Build the table for one position and return the compute answer.
    function automatic answer_t harmonic_build(logic signed [POS_W-1:0] px,
                                               logic signed [POS_W-1:0] py,
                                               logic signed [POS_W-1:0] pz);
        logic signed [POS_W-1:0] p [3];
        logic [NUM_W-1:0] mg [3];
        logic [NUM_W-1:0] r2;
        logic [Q_W-1:0] rq;
        logic signed [Q_W-1:0] u;
        logic signed [Q_W-1:0] s [3];
        logic signed [Q_W-1:0] ra;
        logic signed [Q_W-1:0] e;
        logic signed [Q_W-1:0] he;
        answer_t res;
        int d;
        int mo;
        int c;
        int pv;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        hm_ovf = 0;
        r2 = '0;
        for (int k = 0; k < 3; k++) begin
            mg[k] = NUM_W'($unsigned(p[k][POS_W-1] ? POS_W'(-p[k]) : p[k]));
            r2 = r2 + mg[k] * mg[k];
        end
        if (r2 == 0) begin
            hm_table_ok = 0;
            hm_ovf = 1;
            res = '{v: '0, w: '0, valid: 1'b0, ovf: 1'b1};
            return res;
        end
        rq = root_floor(r2 << 30);
        ra = clamp_mag((NUM_W'(hm_radius) << SCALE_SH) / NUM_W'(rq), 1'b0);
        for (int k = 0; k < 3; k++) begin
            u = clamp_mag((mg[k] << SCALE_SH) / NUM_W'(rq), p[k][POS_W-1]);
            s[k] = qmul(u, ra);
        end
        e = qmul(ra, ra);
        d = hm_degree_reg;
        if (d < 2) d = 2;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        mo = hm_order_reg;
        if (mo > d) mo = d;
        // Zonal column first, then each sectoral seed and its column.
        hm_v[0] = ra;
        hm_w[0] = '0;
        hm_v[1] = qmul(s[2], ra);
        hm_w[1] = '0;
        for (int n = 2; n <= d; n++) begin
            he = qmul(qmul(hm_coef[tix(n, 0)], e), hm_v[tix(n - 2, 0)]);
            hm_v[tix(n, 0)] = qadd(qmul(s[2], hm_v[tix(n - 1, 0)]), he, 1);
            hm_w[tix(n, 0)] = '0;
        end
        for (int m = 1; m <= mo; m++) begin
            pv = tix(m - 1, m - 1);
            c = tix(m, m);
            hm_v[c] = qadd(qmul(s[0], hm_v[pv]), qmul(s[1], hm_w[pv]), 1);
            hm_w[c] = qadd(qmul(s[0], hm_w[pv]), qmul(s[1], hm_v[pv]), 0);
            if (m + 1 <= d) begin
                hm_v[tix(m + 1, m)] = qmul(s[2], hm_v[c]);
                hm_w[tix(m + 1, m)] = qmul(s[2], hm_w[c]);
                for (int n = m + 2; n <= d; n++) begin
                    c = tix(n, m);
                    he = qmul(hm_coef[c], e);
                    hm_v[c] = qadd(qmul(s[2], hm_v[tix(n - 1, m)]),
                                   qmul(he, hm_v[tix(n - 2, m)]), 1);
                    hm_w[c] = qadd(qmul(s[2], hm_w[tix(n - 1, m)]),
                                   qmul(he, hm_w[tix(n - 2, m)]), 1);
                end
            end
        end
        hm_deg = d;
        hm_ord = mo;
        hm_table_ok = 1;
        res = '{v: ra, w: '0, valid: 1'b1, ovf: hm_ovf};
        return res;
    endfunction

    // Work out the answer to an accepted word and queue it.
    task automatic harmonic_predict(logic op, logic signed [POS_W-1:0] px,
                                    logic signed [POS_W-1:0] py,
                                    logic signed [POS_W-1:0] pz,
                                    logic [DEG_W-1:0] n, logic [DEG_W-1:0] m);
        answer_t res;
        bit ok;
        if (op == OP_COMPUTE) begin
            res = harmonic_build(px, py, pz);
            computes++;
        end
        else begin
            ok = hm_table_ok && n <= hm_deg && m <= n && m <= hm_ord;
            res.v = ok ? hm_v[tix(n, m)] : '0;
            res.w = ok ? hm_w[tix(n, m)] : '0;
            res.valid = ok;
            res.ovf = hm_ovf;
            reads++;
        end
        answer_q.push_back(res);
    endtask

    // Offer one word; entered and left on a rising edge. The inputs only
    // change at rising edges, so the value seen at the falling edge is the
    // one the next rising edge samples.
    task automatic send_word(logic op, logic signed [POS_W-1:0] px,
                             logic signed [POS_W-1:0] py,
                             logic signed [POS_W-1:0] pz,
                             logic [DEG_W-1:0] n, logic [DEG_W-1:0] m);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        read_degree <= n;
        read_order <= m;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        harmonic_predict(op, px, py, pz, n, m);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        wait (answer_q.size() == 0);
        @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_EARTH_RADIUS) hm_radius = data;
        else if (idx == REG_DEGREE) hm_degree_reg = data[DEG_W-1:0];
        else if (idx == REG_ORDER) hm_order_reg = data[DEG_W-1:0];
    endtask

    task automatic set_table_shape(logic [RAD_W-1:0] re, int d, int m);
        go_quiet();
        write_reg(REG_EARTH_RADIUS, re);
        write_reg(REG_DEGREE, RAD_W'(d));
        write_reg(REG_ORDER, RAD_W'(m));
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        logic signed [POS_W-1:0] p;
        p = POS_W'({$urandom, $urandom});
        case ($urandom_range(3))
            0: return p;
            1: return p >>> $urandom_range(POS_W - 1);
            default: return p >>> 14;  // roughly planet-sized distances
        endcase
    endfunction

    task automatic send_compute(logic signed [POS_W-1:0] px,
                                logic signed [POS_W-1:0] py,
                                logic signed [POS_W-1:0] pz);
        send_word(OP_COMPUTE, px, py, pz, '0, '0);
    endtask

    // A read mostly inside or just past the computed triangle; the position
    // fields carry noise that the block must ignore.
    task automatic send_read_near();
        int n;
        int m;
        n = $urandom_range(hm_deg + 1);
        m = $urandom_range(n + 1);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(63);
            m = $urandom_range(63);
        end
        send_word(OP_READ, rand_pos(), rand_pos(), rand_pos(), DEG_W'(n), DEG_W'(m));
    endtask

    task automatic test_directed();
        // Read before any table exists.
        send_word(OP_READ, '0, '0, '0, '0, '0);
        // Reset shape: degree and order 22 at a real orbit radius.
        send_compute(48'sd4000000000, -48'sd3000000000, 48'sd5000000000);
        send_word(OP_READ, '0, '0, '0, 6'd0, 6'd0);
        send_word(OP_READ, '0, '0, '0, 6'd22, 6'd22);
        send_word(OP_READ, '0, '0, '0, 6'd22, 6'd0);
        send_word(OP_READ, '0, '0, '0, 6'd9, 6'd4);
        send_word(OP_READ, '0, '0, '0, 6'd3, 6'd5);    // order above degree
        send_word(OP_READ, '0, '0, '0, 6'd23, 6'd1);   // past computed degree
        send_word(OP_READ, POS_MIN, POS_MIN, POS_MIN, 6'd63, 6'd63);
        // Zero position invalidates the table and flags overflow.
        send_compute('0, '0, '0);
        send_word(OP_READ, '0, '0, '0, 6'd1, 6'd0);
        // Extremes of the position fields.
        send_compute(POS_MAX, POS_MIN, POS_MIN);
        send_word(OP_READ, '0, '0, '0, 6'd22, 6'd11);
        send_compute(48'sd1, '0, '0);                  // tiny radius saturates
        send_word(OP_READ, '0, '0, '0, 6'd2, 6'd2);
        send_compute('0, '0, -48'sd7000000000);
        send_word(OP_READ, '0, '0, '0, 6'd4, 6'd0);
    endtask

    task automatic test_register_extremes();
        // Degree clamped up to two, order zero, largest radius.
        set_table_shape(RADIUS_MAX, 0, 0);
        send_compute(48'sd6400000000, 48'sd100, -48'sd20000);
        send_word(OP_READ, '0, '0, '0, 6'd2, 6'd0);
        send_word(OP_READ, '0, '0, '0, 6'd1, 6'd1);
        // Register changes after a compute must not move the read window.
        set_table_shape(1, 5, 5);
        send_word(OP_READ, '0, '0, '0, 6'd3, 6'd0);
        send_word(OP_READ, '0, '0, '0, 6'd3, 6'd1);
        // Smallest radius and a zero radius.
        send_compute(48'sd6400000000, 48'sd6400000000, 48'sd6400000000);
        send_word(OP_READ, '0, '0, '0, 6'd5, 6'd5);
        set_table_shape(0, 4, 63);
        write_reg(REG_UNUSED, RADIUS_MAX);             // must be ignored
        send_compute(-48'sd5000000000, 48'sd1, 48'sd2);
        send_word(OP_READ, '0, '0, '0, 6'd4, 6'd4);
        // Full degree, zonal only, degree clamped down from 63.
        set_table_shape(RADIUS_RESET, 63, 0);
        send_compute(48'sd3000000000, 48'sd3000000000, 48'sd5000000000);
        send_word(OP_READ, '0, '0, '0, 6'd32, 6'd0);
        send_word(OP_READ, '0, '0, '0, 6'd33, 6'd0);
        // The whole triangle once.
        set_table_shape(RADIUS_RESET, 32, 32);
        send_compute(-48'sd2000000000, 48'sd5000000000, -48'sd3500000000);
        send_word(OP_READ, '0, '0, '0, 6'd32, 6'd32);
        send_word(OP_READ, '0, '0, '0, 6'd32, 6'd17);
    endtask

    // A compute first, then mostly reads of the fresh table with computes between.
    task automatic test_random_phase(int s_idle, int r_idle, int words);
        int sent;
        set_table_shape($urandom_range(3) == 0 ? RAD_W'({$urandom, $urandom})
                                               : RADIUS_RESET + $urandom_range(20000),
                        $urandom_range(2, 5), $urandom_range(0, 6));
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < words) begin
            if (sent == 0 || $urandom_range(4) == 0) send_compute(rand_pos(), rand_pos(),
                                                                  rand_pos());
            else send_read_near();
            sent++;
        end
    endtask

    // Stall the output for a long stretch while reads keep coming, then let
    // the sender wait for the block to drain completely.
    task automatic test_backpressure();
        set_table_shape(RADIUS_RESET, 4, 4);
        send_idle = 0;
        recv_idle = 0;
        send_compute(48'sd5000000000, -48'sd1000000000, 48'sd3000000000);
        hold_left = 400;
        repeat (12) send_read_near();
        in_valid <= 1'b0;
        wait (answer_q.size() == 0);
        @(posedge clk);
        repeat (8) send_read_near();
    endtask

    // Output side: random stalls, plus the long hold-off when asked.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Each answer taken at the next rising edge is checked at the falling
    // edge before it, when both handshake signals and the payload are stable.
    always @(negedge clk) begin
        answer_t want;
        if (rst_n && out_valid && out_ready) begin
            checked++;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: word with no answer pending");
            end
            else begin
                want = answer_q.pop_front();
                if (value_v !== want.v || value_w !== want.w
                    || entry_valid !== want.valid || overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: answer %0d: v %h w %h valid %b ovf %b",
                                 checked, value_v, value_w, entry_valid, overflow);
                        $display("       expected v %h w %h valid %b ovf %b",
                                 want.v, want.w, want.valid, want.ovf);
                    end
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $display("timeout with %0d answers outstanding", answer_q.size());
        $finish;
    end

    initial begin
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        mismatches = 0;
        checked = 0;
        computes = 0;
        reads = 0;
        harmonic_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_phase(29, 70, 90);
        test_random_phase(70, 29, 90);
        test_random_phase(0, 0, 90);
        test_backpressure();
        in_valid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d table builds and %0d entry reads, %0d answers checked,",
                 computes, reads, checked);
        $display("across register extremes, stalls on both sides and a full drain.");
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
            $display("%0d mismatches, %0d answers missing", mismatches, answer_q.size());
        end
        $finish;
    end

endmodule
